>>> rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet lookup for the strict base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int unsigned CountWidth = 17;

    // position of a character inside its four-character group
    localparam logic [1:0] GRP_POS0 = 2'd0;
    localparam logic [1:0] GRP_POS1 = 2'd1;
    localparam logic [1:0] GRP_POS2 = 2'd2;
    localparam logic [1:0] GRP_POS3 = 2'd3;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [CountWidth-1:0] LIMIT_RESET = 17'd65536;

    // per-message decoder state
    typedef struct packed {
        logic [1:0]            grp_pos;
        logic [5:0]            prev_sextet;
        logic                  pad_pending;
        logic                  error_seen;
        logic [CountWidth-1:0] decoded_count;
    } dec_state_t;

    // one result item
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
        logic       decode_error;
    } dec_result_t;

    // alphabet lookup: bit 6 set marks a character outside the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = {1'b0, 6'(c - 8'h41)};
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end
        else if (c == 8'h2B)
        begin
            r = {1'b0, 6'd62};
        end
        else if (c == 8'h2F)
        begin
            r = {1'b0, 6'd63};
        end
        return r;
    endfunction

endpackage

>>> rtl/strict_base64_decoder_top.sv
// ----------------------------------------------------------------------------
// strict_base64_decoder_top
// Strict base64 text decoder, one character per request, one byte per result.
// ----------------------------------------------------------------------------
// The block takes one character per clock: the character is decoded against the
// group state and its result is captured in a single output register when it is
// accepted, showing on the output in the cycle after. A new character is taken
// every cycle while the output register is empty or being drained, so sustained
// rate is one character per clock; it drops only while the downstream side stalls.
// Bytes are emitted as soon as complete; the last character's result carries end,
// and error if the message failed; bytes of an errored message must be dropped.
module strict_base64_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,

    // limit on decoded bytes per message
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last_char

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
    output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] decode_error
    output logic        m_axis_tlast    // end_of_message
);

    logic [b64d_pkg::CountWidth-1:0] limit_reg;
    b64d_pkg::dec_state_t            state_reg;
    b64d_pkg::dec_state_t            state_next;
    b64d_pkg::dec_result_t           result;
    logic                            out_valid_reg;
    logic [7:0]                      out_data_reg;
    logic [1:0]                      out_user_reg;
    logic                            out_last_reg;
    logic                            in_accept;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= b64d_pkg::LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    // character decode
    b64d_step u_step
    (
        .state      (state_reg),
        .char_code  (s_axis_tdata),
        .last_char  (s_axis_tlast),
        .max_bytes  (limit_reg),
        .state_next (state_next),
        .result     (result)
    );

    // group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (in_accept)
            state_reg <= state_next;
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= result.valid;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= result.data_byte;
            out_user_reg <= {result.decode_error, result.byte_valid};
            out_last_reg <= result.end_of_message;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // a shown result is either a byte or the end of a message
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_user_reg[0] || out_last_reg))
        else $error("result with neither byte nor end");

    // error is only reported at the end of a message
    a_err_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_user_reg[1]) |-> out_last_reg)
        else $error("error flag without end");

    // the final character restarts the message state
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tlast) |=>
            (state_reg.grp_pos == b64d_pkg::GRP_POS0 && !state_reg.error_seen
             && state_reg.decoded_count == '0))
        else $error("state not cleared after final character");

    // no byte after an error in the same message
    a_no_byte_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && state_reg.error_seen) |=> !out_user_reg[0])
        else $error("byte emitted after error");

endmodule

>>> rtl/b64d_step.sv
// ----------------------------------------------------------------------------
// b64d_step
// Next-state and result logic for one character of the strict decoder.
// ----------------------------------------------------------------------------
module b64d_step
(
    input  b64d_pkg::dec_state_t              state,
    input  logic [7:0]                        char_code,
    input  logic                              last_char,
    input  logic [b64d_pkg::CountWidth-1:0]   max_bytes,
    output b64d_pkg::dec_state_t              state_next,
    output b64d_pkg::dec_result_t             result
);

    logic [6:0]                       lut;
    logic [5:0]                       v;
    logic                             bad;
    logic                             is_pad;
    logic                             err;
    logic                             have_byte;
    logic [7:0]                       byte_val;
    logic [b64d_pkg::CountWidth:0]    cnt_plus;
    logic                             over_limit;

    assign lut        = b64d_pkg::sextet_of(char_code);
    assign v          = lut[5:0];
    assign bad        = lut[6];
    assign is_pad     = (char_code == b64d_pkg::PAD_CHAR);
    assign cnt_plus   = {1'b0, state.decoded_count} + {{b64d_pkg::CountWidth{1'b0}}, 1'b1};
    assign over_limit = cnt_plus > {1'b0, max_bytes};

    // decode and check one character
    always_comb
    begin
        logic [5:0] p;
        p          = state.prev_sextet;
        state_next = state;
        err        = state.error_seen;
        have_byte  = 1'b0;
        byte_val   = 8'd0;

        if (!state.error_seen)
        begin
            unique case (state.grp_pos)
                b64d_pkg::GRP_POS0:
                begin
                    if (bad)
                        err = 1'b1;
                    else
                        state_next.prev_sextet = v;
                end
                b64d_pkg::GRP_POS1:
                begin
                    if (bad)
                        err = 1'b1;
                    else
                    begin
                        byte_val               = {p, v[5:4]};
                        have_byte              = 1'b1;
                        state_next.prev_sextet = v;
                    end
                end
                b64d_pkg::GRP_POS2:
                begin
                    if (is_pad)
                    begin
                        if (p[3:0] != 4'd0)
                            err = 1'b1;
                        else
                            state_next.pad_pending = 1'b1;
                    end
                    else if (bad)
                        err = 1'b1;
                    else
                    begin
                        byte_val               = {p[3:0], v[5:2]};
                        have_byte              = 1'b1;
                        state_next.prev_sextet = v;
                    end
                end
                default:
                begin
                    if (state.pad_pending)
                    begin
                        if (!is_pad || !last_char)
                            err = 1'b1;
                    end
                    else if (is_pad)
                    begin
                        if (p[1:0] != 2'd0 || !last_char)
                            err = 1'b1;
                    end
                    else if (bad)
                        err = 1'b1;
                    else
                    begin
                        byte_val  = {p[1:0], v};
                        have_byte = 1'b1;
                    end
                end
            endcase

            // a final character must close a group
            if (last_char && state.grp_pos != b64d_pkg::GRP_POS3)
                err = 1'b1;

            // output length limit
            if (!err && have_byte)
            begin
                if (over_limit)
                    err = 1'b1;
                else
                    state_next.decoded_count = cnt_plus[b64d_pkg::CountWidth-1:0];
            end

            if (err)
                have_byte = 1'b0;
            state_next.grp_pos    = state.grp_pos + 2'd1;
            state_next.error_seen = err;
        end

        // message restart after the final character
        if (last_char)
            state_next = '0;

        result.valid          = have_byte || last_char;
        result.data_byte      = have_byte ? byte_val : 8'd0;
        result.byte_valid     = have_byte;
        result.end_of_message = last_char;
        result.decode_error   = last_char && err;
    end

endmodule
